// ----- design/rc4_stream_decrypt_assert.svh -----
// Assertion macros shared by the RC4 decryptor. Each macro expects the
// module that uses it to have clk_i in scope, and RC4SD_ASSERT also rst_ni.
`ifndef RC4_STREAM_DECRYPT_ASSERT_SVH
`define RC4_STREAM_DECRYPT_ASSERT_SVH

// Checked only while out of reset.
`define RC4SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define RC4SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/rc4sd_pkg.sv -----
package rc4sd_pkg;

  localparam int KEY_BYTES_DEF = 16;
  localparam int MAX_KEY_BYTES = 16;
  localparam int PERM_DEPTH    = 256;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

  // Sequencer steps.
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_INIT   = 4'd1;
  localparam step_t STEP_SCH0   = 4'd2;
  localparam step_t STEP_SCH1   = 4'd3;
  localparam step_t STEP_SCH2   = 4'd4;
  localparam step_t STEP_SCH3   = 4'd5;
  localparam step_t STEP_SCH4   = 4'd6;
  localparam step_t STEP_SCHEND = 4'd7;
  localparam step_t STEP_KS0    = 4'd8;
  localparam step_t STEP_KS1    = 4'd9;
  localparam step_t STEP_KS2    = 4'd10;
  localparam step_t STEP_KS3    = 4'd11;
  localparam step_t STEP_KS4    = 4'd12;
  localparam step_t STEP_KS5    = 4'd13;
  localparam step_t STEP_KS6    = 4'd14;

  typedef enum logic [2:0] {
    ADDR_N,
    ADDR_J,
    ADDR_I,
    ADDR_I1,
    ADDR_AB
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_N,
    WD_RDATA,
    WD_A
  } wdata_sel_e;

  typedef enum logic [1:0] {
    J_HOLD,
    J_CLR,
    J_ADD,
    J_ADD_KEY
  } j_op_e;

  typedef enum logic [1:0] {
    I_HOLD,
    I_CLR,
    I_INC
  } i_op_e;

  typedef enum logic [1:0] {
    N_HOLD,
    N_CLR,
    N_INC
  } n_op_e;

  typedef enum logic [1:0] {
    K_HOLD,
    K_CLR,
    K_INC
  } k_op_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_DISPATCH,
    COND_LOOP_N,
    COND_GOTO
  } cond_e;

  typedef struct packed {
    addr_sel_e  addr_sel;
    logic       rd_en;
    logic       wr_en;
    wdata_sel_e wdata_sel;
    logic       ld_a;
    logic       ld_b;
    j_op_e      j_op;
    i_op_e      i_op;
    n_op_e      n_op;
    k_op_e      k_op;
    cond_e      cond;
    step_t      target;
    logic       done;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic first;
    logic n_last;
    logic hold;
  } seq_status_t;

endpackage

// ----- design/rc4sd_if.sv -----
interface rc4sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       first_of_message;

  modport source (output valid, output cipher_byte, output first_of_message, input ready);
  modport sink   (input valid, input cipher_byte, input first_of_message, output ready);
endinterface

interface rc4sd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       symbol_ok;

  modport source (output valid, output plain_byte, output symbol_ok, input ready);
  modport sink   (input valid, input plain_byte, input symbol_ok, output ready);
endinterface

// ----- design/rc4sd_ucode.sv -----
module rc4sd_ucode (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rc4sd_pkg::seq_status_t   status_i,
  output rc4sd_pkg::ctrl_word_t    cw_o
);

  rc4sd_pkg::step_t step_q, step_d;

  // Microcode program, one control word per step.
  function automatic rc4sd_pkg::ctrl_word_t rom(input rc4sd_pkg::step_t step);
    rc4sd_pkg::ctrl_word_t cw;
    cw.addr_sel  = rc4sd_pkg::ADDR_N;
    cw.rd_en     = 1'b0;
    cw.wr_en     = 1'b0;
    cw.wdata_sel = rc4sd_pkg::WD_N;
    cw.ld_a      = 1'b0;
    cw.ld_b      = 1'b0;
    cw.j_op      = rc4sd_pkg::J_HOLD;
    cw.i_op      = rc4sd_pkg::I_HOLD;
    cw.n_op      = rc4sd_pkg::N_HOLD;
    cw.k_op      = rc4sd_pkg::K_HOLD;
    cw.cond      = rc4sd_pkg::COND_NEXT;
    cw.target    = rc4sd_pkg::STEP_IDLE;
    cw.done      = 1'b0;
    case (step)
      rc4sd_pkg::STEP_IDLE: begin
        cw.n_op   = rc4sd_pkg::N_CLR;
        cw.k_op   = rc4sd_pkg::K_CLR;
        cw.cond   = rc4sd_pkg::COND_DISPATCH;
        cw.target = rc4sd_pkg::STEP_KS0;
      end
      rc4sd_pkg::STEP_INIT: begin
        cw.addr_sel  = rc4sd_pkg::ADDR_N;
        cw.wr_en     = 1'b1;
        cw.wdata_sel = rc4sd_pkg::WD_N;
        cw.n_op      = rc4sd_pkg::N_INC;
        cw.i_op      = rc4sd_pkg::I_CLR;
        cw.j_op      = rc4sd_pkg::J_CLR;
        cw.cond      = rc4sd_pkg::COND_LOOP_N;
        cw.target    = rc4sd_pkg::STEP_INIT;
      end
      rc4sd_pkg::STEP_SCH0: begin
        cw.addr_sel = rc4sd_pkg::ADDR_N;
        cw.rd_en    = 1'b1;
      end
      rc4sd_pkg::STEP_SCH1: begin
        cw.ld_a = 1'b1;
        cw.j_op = rc4sd_pkg::J_ADD_KEY;
      end
      rc4sd_pkg::STEP_SCH2: begin
        cw.addr_sel = rc4sd_pkg::ADDR_J;
        cw.rd_en    = 1'b1;
      end
      rc4sd_pkg::STEP_SCH3: begin
        cw.addr_sel  = rc4sd_pkg::ADDR_N;
        cw.wr_en     = 1'b1;
        cw.wdata_sel = rc4sd_pkg::WD_RDATA;
      end
      rc4sd_pkg::STEP_SCH4: begin
        cw.addr_sel  = rc4sd_pkg::ADDR_J;
        cw.wr_en     = 1'b1;
        cw.wdata_sel = rc4sd_pkg::WD_A;
        cw.n_op      = rc4sd_pkg::N_INC;
        cw.k_op      = rc4sd_pkg::K_INC;
        cw.cond      = rc4sd_pkg::COND_LOOP_N;
        cw.target    = rc4sd_pkg::STEP_SCH0;
      end
      rc4sd_pkg::STEP_SCHEND: begin
        cw.j_op = rc4sd_pkg::J_CLR;
      end
      rc4sd_pkg::STEP_KS0: begin
        cw.addr_sel = rc4sd_pkg::ADDR_I1;
        cw.rd_en    = 1'b1;
        cw.i_op     = rc4sd_pkg::I_INC;
      end
      rc4sd_pkg::STEP_KS1: begin
        cw.ld_a = 1'b1;
        cw.j_op = rc4sd_pkg::J_ADD;
      end
      rc4sd_pkg::STEP_KS2: begin
        cw.addr_sel = rc4sd_pkg::ADDR_J;
        cw.rd_en    = 1'b1;
      end
      rc4sd_pkg::STEP_KS3: begin
        cw.ld_b      = 1'b1;
        cw.addr_sel  = rc4sd_pkg::ADDR_I;
        cw.wr_en     = 1'b1;
        cw.wdata_sel = rc4sd_pkg::WD_RDATA;
      end
      rc4sd_pkg::STEP_KS4: begin
        cw.addr_sel  = rc4sd_pkg::ADDR_J;
        cw.wr_en     = 1'b1;
        cw.wdata_sel = rc4sd_pkg::WD_A;
      end
      rc4sd_pkg::STEP_KS5: begin
        cw.addr_sel = rc4sd_pkg::ADDR_AB;
        cw.rd_en    = 1'b1;
      end
      rc4sd_pkg::STEP_KS6: begin
        cw.done   = 1'b1;
        cw.cond   = rc4sd_pkg::COND_GOTO;
        cw.target = rc4sd_pkg::STEP_IDLE;
      end
      default: begin
        cw.cond   = rc4sd_pkg::COND_GOTO;
        cw.target = rc4sd_pkg::STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

  assign cw_o = rom(step_q);

  always_comb begin
    step_d = step_q + 1'b1;
    case (cw_o.cond)
      rc4sd_pkg::COND_NEXT: step_d = step_q + 1'b1;
      rc4sd_pkg::COND_DISPATCH: begin
        if (!status_i.in_fire) begin
          step_d = step_q;
        end else if (status_i.first) begin
          step_d = step_q + 1'b1;
        end else begin
          step_d = cw_o.target;
        end
      end
      rc4sd_pkg::COND_LOOP_N: step_d = status_i.n_last ? step_q + 1'b1 : cw_o.target;
      rc4sd_pkg::COND_GOTO:   step_d = cw_o.target;
      default:                step_d = rc4sd_pkg::STEP_IDLE;
    endcase
    if (status_i.hold) begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rc4sd_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- design/rc4sd_dp.sv -----
module rc4sd_dp #(
  parameter int KEY_BYTES = rc4sd_pkg::KEY_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rc4sd_pkg::ctrl_word_t  cw_i,
  input  logic [63:0]            key_low_i,
  input  logic [63:0]            key_high_i,
  output logic                   n_last_o,
  output logic [7:0]             ks_o
);

  localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

  logic [7:0] mem_q [rc4sd_pkg::PERM_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] a_q, b_q;
  logic [7:0] i_q, i_d;
  logic [7:0] j_q, j_d;
  logic [7:0] n_q, n_d;
  logic [KIDX_W-1:0] kidx_q, kidx_d;
  logic [7:0] addr, wdata, key_byte;
  logic [rc4sd_pkg::MAX_KEY_BYTES-1:0][7:0] key_bytes;
  logic [3:0] key_sel;

  assign key_bytes = {key_high_i, key_low_i};
  assign key_sel   = 4'(kidx_q);
  assign key_byte  = key_bytes[key_sel];

  always_comb begin
    case (cw_i.addr_sel)
      rc4sd_pkg::ADDR_N:  addr = n_q;
      rc4sd_pkg::ADDR_J:  addr = j_q;
      rc4sd_pkg::ADDR_I:  addr = i_q;
      rc4sd_pkg::ADDR_I1: addr = i_q + 8'd1;
      rc4sd_pkg::ADDR_AB: addr = a_q + b_q;
      default:            addr = n_q;
    endcase
  end

  always_comb begin
    case (cw_i.wdata_sel)
      rc4sd_pkg::WD_N:     wdata = n_q;
      rc4sd_pkg::WD_RDATA: wdata = rdata_q;
      rc4sd_pkg::WD_A:     wdata = a_q;
      default:             wdata = n_q;
    endcase
  end

  // Single-port permutation memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (cw_i.wr_en) begin
      mem_q[addr] <= wdata;
    end
    if (cw_i.rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_i.ld_a) begin
      a_q <= rdata_q;
    end
    if (cw_i.ld_b) begin
      b_q <= rdata_q;
    end
  end

  always_comb begin
    case (cw_i.j_op)
      rc4sd_pkg::J_HOLD:    j_d = j_q;
      rc4sd_pkg::J_CLR:     j_d = 8'd0;
      rc4sd_pkg::J_ADD:     j_d = j_q + rdata_q;
      rc4sd_pkg::J_ADD_KEY: j_d = j_q + rdata_q + key_byte;
      default:              j_d = j_q;
    endcase
    case (cw_i.i_op)
      rc4sd_pkg::I_CLR: i_d = 8'd0;
      rc4sd_pkg::I_INC: i_d = i_q + 8'd1;
      default:          i_d = i_q;
    endcase
    case (cw_i.n_op)
      rc4sd_pkg::N_CLR: n_d = 8'd0;
      rc4sd_pkg::N_INC: n_d = n_q + 8'd1;
      default:          n_d = n_q;
    endcase
    case (cw_i.k_op)
      rc4sd_pkg::K_CLR: kidx_d = '0;
      rc4sd_pkg::K_INC: kidx_d = (kidx_q == KIDX_LAST) ? '0 : kidx_q + 1'b1;
      default:          kidx_d = kidx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= 8'd0;
      j_q    <= 8'd0;
      n_q    <= 8'd0;
      kidx_q <= '0;
    end else begin
      i_q    <= i_d;
      j_q    <= j_d;
      n_q    <= n_d;
      kidx_q <= kidx_d;
    end
  end

  assign n_last_o = (n_q == 8'hFF);
  assign ks_o     = rdata_q;

endmodule

// ----- design/rc4_stream_decrypt.sv -----
// RC4 stream decryptor with a 128-bit key held in two 64-bit configuration
// registers (key_low at index 0, key_high at index 1). Each input transaction
// carries one ciphertext byte; each yields exactly one output transaction with
// the plaintext byte and a flag that is set when that byte is an ASCII letter,
// digit, space or one of . ' " , : characters. An item with first_of_message
// set first reruns the key schedule from the current key and clears both
// cipher pointers, so a key change takes effect at the next such item; the
// first item after reset must have it set. All work goes through one
// single-port 256-byte permutation memory, sequenced by a microcoded control
// ROM that issues at most one memory access per cycle. An ordinary item runs
// the sequencer through the keystream steps KS0 to KS6 after acceptance, and
// the next item is accepted only once it is back at the idle step. An item that
// starts a message first loads the identity permutation, makes the 256
// schedule swaps and runs the step that clears the pointer. A finished result
// waits in an output register, and the next item is accepted while it waits;
// the sequencer only stalls if a second result is ready before the first one
// has been taken.
`include "rc4_stream_decrypt_assert.svh"

module rc4_stream_decrypt #(
  parameter int KEY_BYTES = rc4sd_pkg::KEY_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rc4sd_in_if.sink                        in_if,
  rc4sd_out_if.source                     out_if,
  input  logic                            cfg_we_i,
  input  logic [rc4sd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                     cfg_wdata_i
);

  // Key registers; the user must write them only while the block is idle, the block itself does not enforce it.
  logic [63:0] key_low_q, key_high_q;

  // The ciphertext byte of the item in flight.
  logic [7:0] cipher_q;

  // Output register that holds a result until the sink takes it.
  logic       out_valid_q;
  logic [7:0] plain_q;
  logic       sym_q;

  rc4sd_pkg::ctrl_word_t  cw;
  rc4sd_pkg::seq_status_t status;
  logic       in_fire;
  logic       out_free;
  logic       out_load;
  logic       n_last;
  logic [7:0] ks;
  logic [7:0] plain_d;

  function automatic logic is_symbol(input logic [7:0] c);
    logic upper, lower, digit, punct;
    upper = (c >= 8'h41) && (c <= 8'h5A);
    lower = (c >= 8'h61) && (c <= 8'h7A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    punct = (c == 8'h20) || (c == 8'h2E) || (c == 8'h27) ||
            (c == 8'h22) || (c == 8'h2C) || (c == 8'h3A);
    return upper || lower || digit || punct;
  endfunction

  // The sequencer's dispatch step is the only one that takes new items.
  assign in_if.ready = (cw.cond == rc4sd_pkg::COND_DISPATCH);
  assign in_fire     = in_if.valid && in_if.ready;

  // The result can be loaded when the output register is empty or is being
  // drained in this same cycle; otherwise the final step waits.
  assign out_free = !out_valid_q || out_if.ready;
  assign out_load = cw.done && out_free;

  assign status.in_fire = in_fire;
  assign status.first   = in_if.first_of_message;
  assign status.n_last  = n_last;
  assign status.hold    = cw.done && !out_free;

  rc4sd_ucode u_ucode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cw_o     (cw)
  );

  rc4sd_dp #(
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cw_i       (cw),
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .n_last_o   (n_last),
    .ks_o       (ks)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= 64'd0;
      key_high_q <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rc4sd_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        rc4sd_pkg::CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cipher_q <= in_if.cipher_byte;
    end
  end

  // The keystream byte is in the memory's read register during the last step.
  assign plain_d = cipher_q ^ ks;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      plain_q <= plain_d;
      sym_q   <= is_symbol(plain_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.plain_byte = plain_q;
  assign out_if.symbol_ok  = sym_q;

  // An accepted item moves the sequencer off the dispatch step at once.
  `RC4SD_ASSERT(a_busy_after_accept, in_fire |=> !in_if.ready,
                "sequencer still accepting right after a transaction")
  // A result that cannot be stored keeps the sequencer on its last step.
  `RC4SD_ASSERT(a_hold_on_full, (cw.done && !out_free) |=> cw.done,
                "final step left while the output register was full")
  // A new result only ever appears from the sequencer's last step.
  `RC4SD_ASSERT(a_valid_from_done, $rose(out_valid_q) |-> $past(cw.done),
                "output became valid without a finished item")
  // Taking input and finishing an item are separate steps.
  `RC4SD_ASSERT_ALWAYS(a_ready_not_done, !(in_if.ready && cw.done),
                       "dispatch and completion overlap")

endmodule

// ----- tb/rc4_stream_decrypt_check.sv -----
// Watches both channels and the key port, keeps its own RC4 state and
// compares every plaintext transaction with the byte and flag it should carry.
module rc4_stream_decrypt_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rc4sd_in_if                             in_if,
  rc4sd_out_if                            out_if,
  input  logic                            cfg_we_i,
  input  logic [rc4sd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                     cfg_wdata_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       symbol_ok;
  } plain_t;

  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;
  logic [7:0]  sbox [rc4sd_pkg::PERM_DEPTH];
  logic [7:0]  ptr_i;
  logic [7:0]  ptr_j;
  plain_t      plain_q [$];
  int          errors = 0;
  int          checked = 0;

  function automatic logic is_text_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == " " || c == "." || c == "'" || c == "\"" || c == "," || c == ":";
  endfunction

  function automatic void run_key_schedule();
    logic [127:0] key;
    logic [7:0]   jj;
    logic [7:0]   t;
    key = {key_hi_q, key_lo_q};
    for (int n = 0; n < rc4sd_pkg::PERM_DEPTH; n++) sbox[n] = 8'(n);
    jj = 8'd0;
    for (int n = 0; n < rc4sd_pkg::PERM_DEPTH; n++) begin
      jj = jj + sbox[n] + key[8*(n % rc4sd_pkg::KEY_BYTES_DEF) +: 8];
      t = sbox[n];
      sbox[n] = sbox[jj];
      sbox[jj] = t;
    end
    ptr_i = 8'd0;
    ptr_j = 8'd0;
  endfunction

  // One keystream step; restarts from the key when the byte opens a message.
  function automatic plain_t decrypt_byte(input logic [7:0] c, input logic first);
    logic [7:0] t;
    logic [7:0] ks;
    logic [7:0] p;
    if (first) run_key_schedule();
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox[ptr_i];
    t = sbox[ptr_i];
    sbox[ptr_i] = sbox[ptr_j];
    sbox[ptr_j] = t;
    ks = sbox[8'(sbox[ptr_i] + sbox[ptr_j])];
    p = c ^ ks;
    return '{plain_byte: p, symbol_ok: is_text_char(p)};
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    plain_t got;
    plain_t want;
    if (!rst_ni) begin
      key_lo_q = '0;
      key_hi_q = '0;
      ptr_i = 8'd0;
      ptr_j = 8'd0;
      plain_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rc4sd_pkg::CFG_KEY_LOW:  key_lo_q = cfg_wdata_i;
          rc4sd_pkg::CFG_KEY_HIGH: key_hi_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got = '{plain_byte: out_if.plain_byte, symbol_ok: out_if.symbol_ok};
        if (plain_q.size() == 0) begin
          report_mismatch($sformatf("plaintext %02h with no ciphertext outstanding",
                                    got.plain_byte));
        end else begin
          want = plain_q.pop_front();
          checked++;
          if (got.plain_byte !== want.plain_byte)
            report_mismatch($sformatf("plain_byte got %02h, expected %02h",
                                      got.plain_byte, want.plain_byte));
          if (got.symbol_ok !== want.symbol_ok)
            report_mismatch($sformatf("symbol_ok got %b, expected %b for byte %02h",
                                      got.symbol_ok, want.symbol_ok, want.plain_byte));
        end
      end
      if (in_if.valid && in_if.ready)
        plain_q.push_back(decrypt_byte(in_if.cipher_byte, in_if.first_of_message));
    end
    errors_o  <= errors;
    pending_o <= plain_q.size();
    checked_o <= checked;
  end

endmodule

// ----- tb/rc4_stream_decrypt_test.sv -----
// Top of the RC4 decryptor testbench. This module only creates stimulus and
// gives the verdict; the checker beside the block predicts and compares.
module rc4_stream_decrypt_test;
  timeunit 1ns;
  timeprecision 1ps;

  // A normal run is dominated by the key schedule of each message start, and
  // the limit lies far above its length so that only a hang ends the run here.
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASE_ITEMS   = 320;
  localparam int RANDOM_PHASES = 6;
  localparam int DRAIN_CYCLES  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rc4sd_in_if  cipher_if ();
  rc4sd_out_if plain_if ();

  logic                            cfg_we;
  logic [rc4sd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [63:0]                     cfg_wdata;

  int errors;
  int pending;
  int checked;

  rc4_stream_decrypt i_dut (
    .clk_i,
    .rst_ni,
    .in_if       (cipher_if),
    .out_if      (plain_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  rc4_stream_decrypt_check i_check (
    .clk_i,
    .rst_ni,
    .in_if       (cipher_if),
    .out_if      (plain_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Run statistics for the closing summary.
  int n_items   = 0;
  int n_starts  = 0;
  int n_keys    = 0;
  int n_long    = 0;

  // Sender pacing. When steady is set the sender never drops valid between
  // transactions; otherwise it sends in bursts separated by idle gaps.
  int burst_left = 0;
  bit steady     = 1'b0;

  // Receiver pacing: bits 11:10 of a free-running cycle counter pick between always
  // ready, mostly ready, long stall runs and a coin toss per cycle.
  logic [31:0] rx_cycle = '0;
  int          rx_hold  = 0;

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst_ni) begin
      plain_if.ready <= 1'b0;
    end else begin
      case (rx_cycle[11:10])
        2'd0: plain_if.ready <= 1'b1;
        2'd1: plain_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2: begin
          if (rx_hold != 0) begin
            plain_if.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            plain_if.ready <= 1'b0;
            rx_hold <= $urandom_range(1, 12);
          end else begin
            plain_if.ready <= 1'b1;
          end
        end
        default: plain_if.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // Watchdog. Results still outstanding at the limit mean the block hung or
  // dropped a transaction.
  int cycles = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one ciphertext byte and returns at the edge where the
  // transaction is accepted. Valid is left high so that the next call can
  // follow back to back; an idle gap lowers it first.
  task automatic send_byte(input logic [7:0] c, input logic first);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(0, 10);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        cipher_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    cipher_if.valid            <= 1'b1;
    cipher_if.cipher_byte      <= c;
    cipher_if.first_of_message <= first;
    do @(posedge clk_i); while (cipher_if.ready !== 1'b1);
    n_items++;
    if (first) n_starts++;
  endtask

  // A message opens with a key schedule. Now and then a byte inside it also
  // carries the start flag, which must restart the cipher from the key.
  task automatic send_message(input int len);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    for (int k = 1; k < len; k++)
      send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 31) == 0));
  endtask

  // Lets every outstanding plaintext transaction come out, then waits out the
  // drain period set by DRAIN_CYCLES so that the block is surely idle before the key changes.
  task automatic drain();
    cipher_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Both key halves are written back to back, the low half first.
  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= rc4sd_pkg::CFG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk_i);
    cfg_idx   <= rc4sd_pkg::CFG_KEY_HIGH;
    cfg_wdata <= hi;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    n_keys++;
  endtask

  initial begin
    int phase_start;
    logic [63:0] lo;
    logic [63:0] hi;

    cipher_if.valid            <= 1'b0;
    cipher_if.cipher_byte      <= 8'h00;
    cipher_if.first_of_message <= 1'b0;
    cfg_we                     <= 1'b0;
    cfg_idx                    <= rc4sd_pkg::CFG_KEY_LOW;
    cfg_wdata                  <= '0;
    rst_ni                     <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the all-zero key. The very first byte must open
    // a message, since the permutation table is unwritten until then.
    load_key('0, '0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b0);
    // Every byte restarts the cipher, so each sees the first keystream byte.
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h80, 1'b1);
    drain();

    // The all-ones key is loaded mid-message: the two bytes that follow
    // still use the old schedule, and it only takes hold at the next start.
    load_key('1, '1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b0);
    drain();

    // Random phases, each under a key of its own. Messages are mostly short;
    // in every other phase the first new message is longer than 256 bytes so that
    // both cipher pointers wrap around.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          lo = 64'h0706_0504_0302_0100;
          hi = 64'h0f0e_0d0c_0b0a_0908;
        end
        1: begin
          lo = '1;
          hi = '0;
        end
        2: begin
          lo = '0;
          hi = '1;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      steady = (p == 2 || p == 4);
      load_key(lo, hi);
      phase_start = n_items;
      // Sometimes the old message simply goes on under the new key.
      if ($urandom_range(0, 1) != 0)
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      if (p % 2 == 1) begin
        send_message($urandom_range(257, 300));
        n_long++;
      end
      while (n_items - phase_start < PHASE_ITEMS)
        send_message($urandom_range(1, 32));
      drain();
    end

    $display("Sent %0d ciphertext bytes with %0d cipher restarts under %0d keys.",
             n_items, n_starts, n_keys);
    $display("Checked %0d plaintext bytes, %0d long messages, %0d cycles.",
             checked, n_long, cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/rc4sd_pkg.sv
design/rc4sd_if.sv
design/rc4sd_ucode.sv
design/rc4sd_dp.sv
design/rc4_stream_decrypt.sv
tb/rc4_stream_decrypt_check.sv
tb/rc4_stream_decrypt_test.sv
